### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros, included by the button press detector.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check that is switched off while reset is applied.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_RST(lbl, prop, msg)

`endif

`endif

### design/bslp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bslp_pkg
// Widths and codes shared by the button press detector and its interfaces.
// ----------------------------------------------------------------------------
package bslp_pkg;

  localparam int FIELD_BITS  = 5;
  localparam int CFG_WIDTH   = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int REQ_W       = 2;
  localparam int SEL_W       = 2;

  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  localparam logic [SEL_W-1:0] SEL_SHORT = 2'd1;
  localparam logic [SEL_W-1:0] SEL_LONG  = 2'd2;

  localparam int SEL_BIT_SHORT = 0;
  localparam int SEL_BIT_LONG  = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_LOW   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_HIGH  = 2'd3;

  localparam logic [CFG_WIDTH-1:0] SHORT_LOW_RST  = 16'd5;
  localparam logic [CFG_WIDTH-1:0] SHORT_HIGH_RST = 16'd100;
  localparam logic [CFG_WIDTH-1:0] LONG_LOW_RST   = 16'd200;
  localparam logic [CFG_WIDTH-1:0] LONG_HIGH_RST  = 16'd1000;

endpackage

### design/bslp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bslp_if
// Request and result channels of the button press detector.
// ----------------------------------------------------------------------------
interface bslp_in_if;
  import bslp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [REQ_W-1:0]      req_type;
  logic [FIELD_BITS-1:0] pin_levels;
  logic [FIELD_BITS-1:0] key_mask;
  logic [SEL_W-1:0]      press_select;

  modport source (
    output valid, req_type, pin_levels, key_mask, press_select,
    input  ready
  );
  modport sink (
    input  valid, req_type, pin_levels, key_mask, press_select,
    output ready
  );
endinterface

interface bslp_out_if;
  import bslp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  flag_value;
  logic [FIELD_BITS-1:0] short_flags;
  logic [FIELD_BITS-1:0] long_flags;

  modport source (
    output valid, flag_value, short_flags, long_flags,
    input  ready
  );
  modport sink (
    input  valid, flag_value, short_flags, long_flags,
    output ready
  );
endinterface

### design/button_short_long_press_detector.sv
// Path: an accepted item goes from the input register to the result register;
// it waits in the input register while an unaccepted result is held.
// Throughput: one item per cycle while results are taken; the input register and
// the result register each hold one item, so one input can be taken while a result waits.
// Reset: synchronous, active low; thresholds return to their defaults,
// counters and flags clear and every key reads as released.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_short_long_press_detector
// Sticky short-press and long-press flags for a set of active-low keys.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module button_short_long_press_detector #(
  parameter int NUM_KEYS    = 5,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  bslp_in_if.sink                          in_ch,
  bslp_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [bslp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bslp_pkg::CFG_WIDTH-1:0]   cfg_wdata
);
  import bslp_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [CMP_W-1:0]       cmp_t;

  typedef struct packed {
    logic [REQ_W-1:0]      req_type;
    logic [FIELD_BITS-1:0] pin_levels;
    logic [FIELD_BITS-1:0] key_mask;
    logic [SEL_W-1:0]      press_select;
  } req_item_t;

  logic [CFG_WIDTH-1:0] short_low_r, short_high_r, long_low_r, long_high_r;

  logic      s1_valid_r;
  req_item_t s1_item_r;
  logic      in_ready;
  logic      adv;

  logic                  out_valid_r;
  logic                  out_flag_r;
  logic [FIELD_BITS-1:0] out_short_r;
  logic [FIELD_BITS-1:0] out_long_r;

  logic [NUM_KEYS-1:0] last_levels_r, last_levels_nxt;
  logic [NUM_KEYS-1:0] short_flags_r, short_flags_nxt;
  logic [NUM_KEYS-1:0] long_flags_r, long_flags_nxt;
  count_t              short_cnt_r [NUM_KEYS];
  count_t              short_cnt_nxt [NUM_KEYS];
  count_t              long_cnt_r [NUM_KEYS];
  count_t              long_cnt_nxt [NUM_KEYS];
  count_t              short_inc [NUM_KEYS];
  count_t              long_inc [NUM_KEYS];
  logic [NUM_KEYS-1:0] short_ok;
  logic [NUM_KEYS-1:0] long_hit;
  logic [NUM_KEYS-1:0] pin_ext;
  logic [NUM_KEYS-1:0] mask_ext;
  logic                top_short, top_long;
  logic                flag_nxt;

  logic [FIELD_BITS-1:0] short_vis, long_vis;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_low_r  <= SHORT_LOW_RST;
      short_high_r <= SHORT_HIGH_RST;
      long_low_r   <= LONG_LOW_RST;
      long_high_r  <= LONG_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHORT_LOW:  short_low_r  <= cfg_wdata;
        CFG_SHORT_HIGH: short_high_r <= cfg_wdata;
        CFG_LONG_LOW:   long_low_r   <= cfg_wdata;
        CFG_LONG_HIGH:  long_high_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv          = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready     = !s1_valid_r || adv;
  assign in_ch.ready  = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ready) begin
      s1_item_r.req_type     <= in_ch.req_type;
      s1_item_r.pin_levels   <= in_ch.pin_levels;
      s1_item_r.key_mask     <= in_ch.key_mask;
      s1_item_r.press_select <= in_ch.press_select;
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    if (k < FIELD_BITS) begin : g_in
      assign pin_ext[k]  = s1_item_r.pin_levels[k];
      assign mask_ext[k] = s1_item_r.key_mask[k];
    end else begin : g_out
      assign pin_ext[k]  = 1'b1;
      assign mask_ext[k] = 1'b0;
    end
  end

  for (genvar b = 0; b < FIELD_BITS; b++) begin : g_vis
    if (b < NUM_KEYS) begin : g_key_bit
      assign short_vis[b] = short_flags_nxt[b];
      assign long_vis[b]  = long_flags_nxt[b];
    end else begin : g_pad
      assign short_vis[b] = 1'b0;
      assign long_vis[b]  = 1'b0;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      short_inc[k] = (short_cnt_r[k] == '1) ? short_cnt_r[k]
                                            : short_cnt_r[k] + COUNT_WIDTH'(1);
      long_inc[k]  = (long_cnt_r[k] == '1) ? long_cnt_r[k]
                                           : long_cnt_r[k] + COUNT_WIDTH'(1);
      short_ok[k]  = (cmp_t'(short_low_r) < cmp_t'(short_cnt_r[k])) &&
                     (cmp_t'(short_cnt_r[k]) < cmp_t'(short_high_r));
      long_hit[k]  = (cmp_t'(long_low_r) < cmp_t'(long_inc[k])) &&
                     (cmp_t'(long_inc[k]) < cmp_t'(long_high_r));
    end
  end

  always_comb begin
    last_levels_nxt = last_levels_r;
    short_flags_nxt = short_flags_r;
    long_flags_nxt  = long_flags_r;
    short_cnt_nxt   = short_cnt_r;
    long_cnt_nxt    = long_cnt_r;
    top_short       = 1'b0;
    top_long        = 1'b0;
    flag_nxt        = 1'b0;
    case (s1_item_r.req_type)
      REQ_SAMPLE: begin
        for (int k = 0; k < NUM_KEYS; k++) begin
          if (pin_ext[k] && !last_levels_r[k]) begin
            if (short_ok[k] && !long_flags_r[k]) begin
              short_flags_nxt[k] = 1'b1;
            end
            short_cnt_nxt[k] = '0;
          end else if (!pin_ext[k] && last_levels_r[k]) begin
            short_cnt_nxt[k] = '0;
          end else if (!pin_ext[k] && !last_levels_r[k]) begin
            short_cnt_nxt[k] = short_inc[k];
            if (long_hit[k]) begin
              long_flags_nxt[k] = 1'b1;
              long_cnt_nxt[k]   = '0;
            end else begin
              long_cnt_nxt[k] = long_inc[k];
            end
          end
          last_levels_nxt[k] = pin_ext[k];
        end
      end
      REQ_CLEAR: begin
        for (int k = 0; k < NUM_KEYS; k++) begin
          if (mask_ext[k]) begin
            if (s1_item_r.press_select[SEL_BIT_SHORT]) begin
              short_flags_nxt[k] = 1'b0;
              short_cnt_nxt[k]   = '0;
              last_levels_nxt[k] = 1'b1;
            end
            if (s1_item_r.press_select[SEL_BIT_LONG]) begin
              long_flags_nxt[k] = 1'b0;
              long_cnt_nxt[k]   = '0;
            end
          end
        end
      end
      REQ_QUERY: begin
        for (int k = 0; k < NUM_KEYS; k++) begin
          if (mask_ext[k]) begin
            top_short = short_flags_r[k];
            top_long  = long_flags_r[k];
          end
        end
        if (s1_item_r.press_select == SEL_SHORT) begin
          flag_nxt = top_short;
        end else if (s1_item_r.press_select == SEL_LONG) begin
          flag_nxt = top_long;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_levels_r <= '1;
      short_flags_r <= '0;
      long_flags_r  <= '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        short_cnt_r[k] <= '0;
        long_cnt_r[k]  <= '0;
      end
    end else if (adv) begin
      last_levels_r <= last_levels_nxt;
      short_flags_r <= short_flags_nxt;
      long_flags_r  <= long_flags_nxt;
      short_cnt_r   <= short_cnt_nxt;
      long_cnt_r    <= long_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (adv) begin
      out_flag_r  <= flag_nxt;
      out_short_r <= short_vis;
      out_long_r  <= long_vis;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.flag_value  = out_flag_r;
  assign out_ch.short_flags = out_short_r;
  assign out_ch.long_flags  = out_long_r;

  `ASSERT_RST(a_no_result_after_reset, !rst_n |=> !out_valid_r,
              "result valid directly after reset")
  `ASSERT_CLK(a_flag_only_on_query,
              adv && (s1_item_r.req_type != REQ_QUERY) |=> !out_flag_r,
              "flag value set for an item that is not a query")
  `ASSERT_CLK(a_long_set_only_by_sample,
              adv && (s1_item_r.req_type != REQ_SAMPLE) |=>
              ((long_flags_r & ~$past(long_flags_r)) == '0),
              "long flag raised by an item that is not a sample tick")
  `ASSERT_CLK(a_sample_keeps_flags,
              adv && (s1_item_r.req_type == REQ_SAMPLE) |=>
              ((($past(short_flags_r) & ~short_flags_r) == '0) &&
               (($past(long_flags_r) & ~long_flags_r) == '0)),
              "sample tick cleared a sticky flag")

endmodule
